FILE: hdl/tcw_pkg.sv
// Shared types, constants and control codes of the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int STORE_CELLS_DEF = 8192;
    localparam int TAB_STOP_DEF    = 8;

    localparam int IDX_W   = 13;
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h02;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTR  = 1'b0,
        CFG_BLANK = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_COPY,
        ST_BLANK,
        ST_POST,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        POST_NONE,
        POST_CR,
        POST_GLYPH
    } post_t;

    typedef struct packed {
        action_t            action;
        logic [CHAR_W-1:0]  char_byte;
        logic               end_of_write;
        logic [IDX_W-1:0]   read_index;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   shown_cursor;
        logic [IDX_W-1:0]   start_cell;
        logic [CELL_W-1:0]  cell_data;
    } result_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [CELL_W-1:0]  wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

endpackage

FILE: hdl/tcw_vram.sv
// Character-cell video memory with one write port and one registered read port.
module tcw_vram
    import tcw_pkg::*;
#(
    parameter int STORE_CELLS = STORE_CELLS_DEF
)
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [CELL_W-1:0] rdata
);

    localparam int AW = $clog2(STORE_CELLS);

    logic [CELL_W-1:0] mem [STORE_CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/tcw_ctrl.sv
// Sequencer of the text console: cursor state, control codes, scroll, copy and clear sweeps.
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int ROWS        = ROWS_DEF,
    parameter int STORE_CELLS = STORE_CELLS_DEF,
    parameter int TAB_STOP    = TAB_STOP_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    input  logic [ATTR_W-1:0] attr,
    input  logic [CELL_W-1:0] blank,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           result,
    output mem_req_t          mem_req,
    input  logic [CELL_W-1:0] mem_rdata
);

    localparam int AW   = $clog2(STORE_CELLS);
    localparam int COLW = $clog2(COLUMNS + 1);
    localparam int RW   = $clog2(ROWS);
    localparam int PW   = $clog2(TAB_STOP);
    localparam int CNTW = AW + 1;
    localparam int SC   = COLUMNS * ROWS;
    localparam int CM   = COLUMNS % TAB_STOP;

    localparam logic [AW-1:0]   COL_A       = AW'(COLUMNS);
    localparam logic [AW-1:0]   SC_A        = AW'(SC);
    localparam logic [AW:0]     COPY_LIMIT  = (AW + 1)'(STORE_CELLS - SC - COLUMNS);
    localparam logic [COLW:0]   COL_X       = (COLW + 1)'(COLUMNS);
    localparam logic [PW:0]     TAB_X       = (PW + 1)'(TAB_STOP);
    localparam logic [PW-1:0]   PH_CM       = PW'(CM);
    localparam logic [PW-1:0]   PH_TAB_WRAP = PW'((TAB_STOP - CM) % TAB_STOP);
    localparam logic [PW-1:0]   PH_LAST     = PW'(TAB_STOP - 1);
    localparam logic [PW-1:0]   PH_WRAP_ADD = PW'(TAB_STOP - CM);
    localparam logic [RW-1:0]   ROW_LAST    = RW'(ROWS - 1);
    localparam logic [CNTW-1:0] SWEEP_LAST  = CNTW'(STORE_CELLS - 1);
    localparam logic [CNTW-1:0] COPY_LAST   = CNTW'(SC);
    localparam logic [CNTW-1:0] BLANK_LAST  = CNTW'(COLUMNS - 1);

    state_t             state_reg, state_next;
    post_t              post_reg, post_next;
    item_t              item_reg, item_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]      start_reg, start_next;
    logic [AW-1:0]      cell_reg, cell_next;
    logic [COLW-1:0]    col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [PW-1:0]      phase_reg, phase_next;
    logic [AW-1:0]      pub_reg, pub_next;
    logic [CELL_W-1:0]  sweep_reg, sweep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            post_reg  <= POST_NONE;
            cnt_reg   <= '0;
            start_reg <= '0;
            cell_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
            pub_reg   <= '0;
            sweep_reg <= BLANK_RESET;
        end
        else
        begin
            state_reg <= state_next;
            post_reg  <= post_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
            cell_reg  <= cell_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            pub_reg   <= pub_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_comb
    begin
        logic [COLW:0]      col_x;
        logic [PW:0]        tab_step;
        logic [COLW:0]      tab_col;
        logic [AW-1:0]      tab_cell;
        logic [CELL_W-1:0]  glyph;
        logic [PW-1:0]      phase_inc;
        logic [PW-1:0]      phase_dec;
        logic [PW-1:0]      phase_wrap;
        logic [IDX_W-1:0]   ridx;
        logic [AW-1:0]      pub_val;
        logic               lf_go;
        logic [AW-1:0]      lf_base;
        post_t              lf_post;

        state_next = state_reg;
        post_next  = post_reg;
        item_next  = item_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        cell_next  = cell_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        pub_next   = pub_reg;
        sweep_next = sweep_reg;
        mem_req    = '0;
        item_ready = (state_reg == ST_IDLE);
        res_valid  = 1'b0;
        result     = '0;

        col_x      = {1'b0, col_reg};
        tab_step   = TAB_X - {1'b0, phase_reg};
        tab_col    = col_x + (COLW + 1)'(tab_step);
        tab_cell   = cell_reg + AW'(tab_step);
        glyph      = {attr, item_reg.char_byte};
        phase_inc  = (phase_reg == PH_LAST) ? '0 : phase_reg + PW'(1);
        phase_dec  = (phase_reg == '0) ? PH_LAST : phase_reg - PW'(1);
        phase_wrap = (phase_reg >= PH_CM) ? phase_reg - PH_CM : phase_reg + PH_WRAP_ADD;
        ridx       = (32'(item_reg.read_index) >= STORE_CELLS)
                     ? item_reg.read_index - IDX_W'(STORE_CELLS) : item_reg.read_index;
        pub_val    = (item_reg.action == ACT_PUT && item_reg.end_of_write) ? cell_reg : pub_reg;
        lf_go      = 1'b0;
        lf_base    = cell_reg;
        lf_post    = POST_NONE;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(cnt_reg[AW-1:0]);
                mem_req.wdata = sweep_reg;
                if (cnt_reg == SWEEP_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (item_reg.action)
                    ACT_PUT:
                    begin
                        case (item_reg.char_byte)
                            CH_NUL:
                            begin
                                state_next = ST_DONE;
                            end
                            CH_BS:
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next      = col_reg - COLW'(1);
                                    cell_next     = cell_reg - AW'(1);
                                    phase_next    = phase_dec;
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = IDX_W'(cell_reg - AW'(1));
                                    mem_req.wdata = blank;
                                end
                            end
                            CH_DEL:
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = IDX_W'(cell_reg);
                                mem_req.wdata = blank;
                            end
                            CH_HT:
                            begin
                                if (tab_col >= COL_X)
                                begin
                                    col_next   = COLW'(tab_col - COL_X);
                                    phase_next = PH_TAB_WRAP;
                                    lf_go      = 1'b1;
                                    lf_base    = tab_cell - COL_A;
                                end
                                else
                                begin
                                    col_next   = COLW'(tab_col);
                                    cell_next  = tab_cell;
                                    phase_next = '0;
                                end
                            end
                            CH_LF:
                            begin
                                lf_go   = 1'b1;
                                lf_post = POST_CR;
                            end
                            CH_VT, CH_FF:
                            begin
                                lf_go = 1'b1;
                            end
                            default:
                            begin
                                if (col_x >= COL_X)
                                begin
                                    col_next   = COLW'(col_x - COL_X);
                                    phase_next = phase_wrap;
                                    lf_go      = 1'b1;
                                    lf_base    = cell_reg - COL_A;
                                    lf_post    = POST_GLYPH;
                                end
                                else
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = IDX_W'(cell_reg);
                                    mem_req.wdata = glyph;
                                    cell_next     = cell_reg + AW'(1);
                                    col_next      = col_reg + COLW'(1);
                                    phase_next    = phase_inc;
                                end
                            end
                        endcase
                    end
                    ACT_CLEAR:
                    begin
                        start_next = '0;
                        cell_next  = '0;
                        col_next   = '0;
                        row_next   = '0;
                        phase_next = '0;
                        pub_next   = '0;
                        sweep_next = blank;
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    ACT_READ:
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = ridx;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase

                if (lf_go)
                begin
                    post_next = lf_post;
                    if (row_reg != ROW_LAST)
                    begin
                        row_next   = row_reg + RW'(1);
                        cell_next  = lf_base + COL_A;
                        state_next = ST_POST;
                    end
                    else
                    begin
                        cell_next  = lf_base;
                        state_next = ST_SCROLL;
                    end
                end
            end

            ST_SCROLL:
            begin
                cnt_next = '0;
                if ({1'b0, start_reg} >= COPY_LIMIT)
                begin
                    cell_next  = cell_reg - start_reg;
                    state_next = ST_COPY;
                end
                else
                begin
                    state_next = ST_BLANK;
                end
            end

            ST_COPY:
            begin
                if (cnt_reg != COPY_LAST)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(start_reg + cnt_reg[AW-1:0]);
                end
                if (cnt_reg != '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = IDX_W'(cnt_reg[AW-1:0] - AW'(1));
                    mem_req.wdata = mem_rdata;
                end
                if (cnt_reg == COPY_LAST)
                begin
                    start_next = '0;
                    cnt_next   = '0;
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            ST_BLANK:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(start_reg + SC_A + cnt_reg[AW-1:0]);
                mem_req.wdata = blank;
                if (cnt_reg == BLANK_LAST)
                begin
                    cnt_next   = '0;
                    start_next = start_reg + COL_A;
                    cell_next  = cell_reg + COL_A;
                    state_next = ST_POST;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            ST_POST:
            begin
                state_next = ST_DONE;
                case (post_reg)
                    POST_CR:
                    begin
                        cell_next  = cell_reg - AW'(col_reg);
                        col_next   = '0;
                        phase_next = '0;
                    end
                    POST_GLYPH:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = IDX_W'(cell_reg);
                        mem_req.wdata = glyph;
                        cell_next     = cell_reg + AW'(1);
                        col_next      = col_reg + COLW'(1);
                        phase_next    = phase_inc;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DONE:
            begin
                res_valid           = 1'b1;
                result.shown_cursor = IDX_W'(pub_val);
                result.start_cell   = IDX_W'(start_reg);
                result.cell_data    = (item_reg.action == ACT_READ) ? mem_rdata : '0;
                if (res_ready)
                begin
                    pub_next   = pub_val;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_LAST)
        else $error("cursor row beyond the last screen row");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) <= COLUMNS)
        else $error("cursor column beyond the deferred wrap position");

    a_cursor_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |->
        32'(cell_reg) == 32'(start_reg) + 32'(row_reg) * COLUMNS + 32'(col_reg))
        else $error("cursor cell out of step with start, row and column");

    a_start_fits: assert property (@(posedge clk) disable iff (!rst_n)
        32'(start_reg) + SC <= STORE_CELLS)
        else $error("visible screen runs past the end of the store");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && !res_ready |=> state_reg == ST_DONE && $stable(start_reg))
        else $error("pending result changed before it was handed over");

endmodule

FILE: hdl/text_console_writer.sv
// Top level of the text console writer: stream ports, configuration registers, output register.
//
//  Channel   Direction  Handshake               Payload
//  s_axis    in         s_axis_tvalid/tready    tuser action, tlast end_of_write, tdata byte+index
//  m_axis    out        m_axis_tvalid/tready    tdata shown cursor, screen start, cell word
//  cfg       in         cfg_valid/cfg_ready     cfg_index register, cfg_data value
//
// After reset the whole store is swept with the reset blank word before the first
// input transfer is taken; configuration writes are taken throughout.
// A plain byte, another control code or a cell read passes the sequencer states EXEC and DONE
// and then the output register; a line feed, a vertical tab, a form feed, or a tab or glyph that
// wraps also passes POST, and on the last row a scroll first (SCROLL, then BLANK of the new row),
// and a scroll that copies the visible cells back to cell 0 also runs a COPY sweep before BLANK.
// A clear screen sweeps the whole store with one store write per cycle.
// A new item is taken while the previous result waits in the output register.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int ROWS        = ROWS_DEF,
    parameter int STORE_CELLS = STORE_CELLS_DEF,
    parameter int TAB_STOP    = TAB_STOP_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // char_byte[7:0], read_index[20:8]
    input  logic [ACT_W-1:0]     s_axis_tuser,   // action[1:0]
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // shown_cursor[12:0], start_cell[25:13],
                                                 // cell_data[41:26]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CELL_W-1:0]    cfg_data
);

    logic [ATTR_W-1:0] attr_reg;
    logic [CELL_W-1:0] blank_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;

    item_t             item;
    logic              res_valid;
    logic              res_ready;
    result_t           result;
    mem_req_t          mem_req;
    logic [CELL_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg  <= ATTR_RESET;
            blank_reg <= BLANK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ATTR:
                begin
                    attr_reg <= cfg_data[ATTR_W-1:0];
                end
                CFG_BLANK:
                begin
                    blank_reg <= cfg_data;
                end
                default:
                begin
                    blank_reg <= blank_reg;
                end
            endcase
        end
    end

    assign item.action       = action_t'(s_axis_tuser);
    assign item.char_byte    = s_axis_tdata[7:0];
    assign item.end_of_write = s_axis_tlast;
    assign item.read_index   = s_axis_tdata[20:8];

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_data_reg.cell_data, out_data_reg.start_cell,
                            out_data_reg.shown_cursor};

    tcw_ctrl #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .STORE_CELLS (STORE_CELLS),
        .TAB_STOP    (TAB_STOP)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item       (item),
        .attr       (attr_reg),
        .blank      (blank_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result     (result),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    tcw_vram #(
        .STORE_CELLS (STORE_CELLS)
    ) u_vram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule
